### src/morse_character_keyer_unit_defines.svh
// Assertion macros shared by the Morse keyer checker.
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mck_pkg.sv
// Types and constants shared by the Morse character keyer modules.
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DOT_W  = 10;
  localparam int unsigned DUR_W  = 12;

  localparam logic [DOT_W-1:0] DOT_RESET = 10'd100;

  // ASCII codes that the front end tests for.
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;

  localparam int unsigned LETTERS = 26;

  // Number of symbols of each letter, A first.
  localparam logic [2:0] SYM_COUNT [LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Bit i set means symbol i (sent first is bit 0) is a dash.
  localparam logic [3:0] SYM_DASH [LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  // Segment lengths in dot periods.
  localparam logic [2:0] UNITS_DOT  = 3'd1;
  localparam logic [2:0] UNITS_GAP  = 3'd2;
  localparam logic [2:0] UNITS_DASH = 3'd3;
  localparam logic [2:0] UNITS_WORD = 3'd4;

  // One classified character waiting to be keyed.
  typedef struct packed {
    logic       is_space;
    logic [2:0] sym_count;
    logic [3:0] dash;
  } job_t;

  // Segment that the sequencer emits next.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_SPACE,
    PH_GAP
  } phase_e;

endpackage

`default_nettype wire

### src/mck_front.sv
// Front end: takes characters and turns letters and spaces into keying jobs.
`timescale 1ns / 1ps
`default_nettype none

module mck_front (
  input  logic                      start_i,
  input  logic                      full_i,
  input  logic [mck_pkg::CHAR_W-1:0] character_i,
  output logic                      push_o,
  output mck_pkg::job_t             job_o
);

  logic                      is_upper;
  logic                      is_lower;
  logic                      is_space;
  logic [mck_pkg::CHAR_W-1:0] offset;
  logic [4:0]                letter_idx;

  // Classify the character and look up its symbol pattern.
  always_comb begin
    is_upper = character_i inside {[mck_pkg::UPPER_A:mck_pkg::UPPER_Z]};
    is_lower = character_i inside {[mck_pkg::LOWER_A:mck_pkg::LOWER_Z]};
    is_space = (character_i == mck_pkg::CHAR_SPACE);
    offset   = is_lower ? (character_i - mck_pkg::LOWER_A)
                        : (character_i - mck_pkg::UPPER_A);
    letter_idx = offset[4:0];

    job_o.is_space  = is_space;
    job_o.sym_count = 3'd0;
    job_o.dash      = 4'd0;
    if (is_upper || is_lower) begin
      job_o.sym_count = mck_pkg::SYM_COUNT[letter_idx];
      job_o.dash      = mck_pkg::SYM_DASH[letter_idx];
    end
  end

  // Only letters and spaces produce work; anything else is dropped on transfer.
  assign push_o = start_i && !full_i && (is_upper || is_lower || is_space);

endmodule

`default_nettype wire

### src/mck_fifo.sv
// Short job queue between the front end and the keying sequencer.
`timescale 1ns / 1ps
`default_nettype none

module mck_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mck_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output mck_pkg::job_t data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mck_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### src/mck_back.sv
// Back end: steps through a job and emits one keying segment per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mck_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mck_pkg::DOT_W-1:0]  dot_period_i,
  input  logic                       head_valid_i,
  input  mck_pkg::job_t              head_i,
  output logic                       pop_o,
  output logic                       strobe_o,
  output logic                       led_on_o,
  output logic [mck_pkg::DUR_W-1:0]  duration_ms_o,
  output logic                       last_o
);

  mck_pkg::phase_e state_q, state_d;
  mck_pkg::job_t   job_q, job_d;
  logic [1:0]      sym_q, sym_d;

  mck_pkg::job_t   cur_job;
  mck_pkg::phase_e cur_ph;
  mck_pkg::phase_e next_ph;
  logic [1:0]      cur_sym;
  logic [1:0]      next_sym;
  logic [1:0]      last_sym;
  logic            emit;
  logic            seg_led;
  logic            seg_last;
  logic [2:0]      seg_units;
  logic [mck_pkg::DUR_W-1:0] dot_ext;
  logic [mck_pkg::DUR_W-1:0] seg_dur;

  logic                      strobe_q;
  logic                      led_q;
  logic                      last_q;
  logic [mck_pkg::DUR_W-1:0] dur_q;

  // Sequencer: when idle the head of the queue is keyed straight away.
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    sym_d   = sym_q;
    pop_o   = 1'b0;

    if (state_q == mck_pkg::PH_IDLE) begin
      cur_job = head_i;
      cur_sym = 2'd0;
      cur_ph  = head_i.is_space ? mck_pkg::PH_GAP : mck_pkg::PH_MARK;
      emit    = head_valid_i;
      pop_o   = head_valid_i;
      if (head_valid_i) begin
        job_d = head_i;
      end
    end else begin
      cur_job = job_q;
      cur_sym = sym_q;
      cur_ph  = state_q;
      emit    = 1'b1;
    end

    last_sym  = 2'(cur_job.sym_count - 3'd1);
    next_ph   = mck_pkg::PH_IDLE;
    next_sym  = cur_sym;
    seg_led   = 1'b0;
    seg_last  = 1'b0;
    seg_units = mck_pkg::UNITS_DOT;

    case (cur_ph)
      mck_pkg::PH_MARK: begin
        seg_led   = 1'b1;
        seg_units = cur_job.dash[cur_sym] ? mck_pkg::UNITS_DASH : mck_pkg::UNITS_DOT;
        next_ph   = mck_pkg::PH_SPACE;
      end
      mck_pkg::PH_SPACE: begin
        seg_units = mck_pkg::UNITS_DOT;
        if (cur_sym == last_sym) begin
          next_ph = mck_pkg::PH_GAP;
        end else begin
          next_ph  = mck_pkg::PH_MARK;
          next_sym = cur_sym + 2'd1;
        end
      end
      mck_pkg::PH_GAP: begin
        seg_last  = 1'b1;
        seg_units = cur_job.is_space ? mck_pkg::UNITS_WORD : mck_pkg::UNITS_GAP;
        next_ph   = mck_pkg::PH_IDLE;
      end
      default: begin
        next_ph = mck_pkg::PH_IDLE;
      end
    endcase

    if (emit) begin
      state_d = next_ph;
      sym_d   = next_sym;
    end
  end

  // Segment length: the dot period times a small constant, by shift and add.
  assign dot_ext = {{(mck_pkg::DUR_W - mck_pkg::DOT_W){1'b0}}, dot_period_i};

  always_comb begin
    case (seg_units)
      mck_pkg::UNITS_DOT:  seg_dur = dot_ext;
      mck_pkg::UNITS_GAP:  seg_dur = {dot_ext[mck_pkg::DUR_W-2:0], 1'b0};
      mck_pkg::UNITS_DASH: seg_dur = dot_ext + {dot_ext[mck_pkg::DUR_W-2:0], 1'b0};
      mck_pkg::UNITS_WORD: seg_dur = {dot_ext[mck_pkg::DUR_W-3:0], 2'b00};
      default:             seg_dur = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mck_pkg::PH_IDLE;
      sym_q    <= 2'd0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sym_q    <= sym_d;
      strobe_q <= emit;
    end
  end

  // Job and result payload registers.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      led_q  <= seg_led;
      last_q <= seg_last;
      dur_q  <= seg_dur;
    end
  end

  assign strobe_o      = strobe_q;
  assign led_on_o      = led_q;
  assign last_o        = last_q;
  assign duration_ms_o = dur_q;

endmodule

`default_nettype wire

### src/morse_character_keyer_unit.sv
// Top level of the Morse character keyer.
//
// Channels: a character is transferred at a rising edge with start high and
// busy low. Letters (either case) and the space character are keyed; any
// other code is taken and gives no segment. Each segment appears on led_on_o,
// duration_ms_o and last_o for exactly one cycle with strobe_o high; last_o
// marks the final segment of a character. The dot period is written through
// cfg_valid_i / cfg_data_i, which is always ready; the user must write it
// only while the block is idle; the block does not enforce this. The first
// segment of a character passes through the job queue and output registers.
// The sequencer emits one segment per cycle while it has a job; a letter
// gives 3 to 9 segments, a space one. A queue of QUEUE_DEPTH jobs lets the
// front take characters meanwhile; busy is high only while the queue is full.
// Reset clears the queue and the sequencer and sets the dot period to 100.
// The receiver cannot stall; every strobe is a completed transfer.
`timescale 1ns / 1ps
`default_nettype none

module morse_character_keyer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [mck_pkg::CHAR_W-1:0] character_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mck_pkg::DOT_W-1:0]  cfg_data_i,
  output logic                       strobe_o,
  output logic                       led_on_o,
  output logic [mck_pkg::DUR_W-1:0]  duration_ms_o,
  output logic                       last_o
);

  logic [mck_pkg::DOT_W-1:0] dot_q;
  logic                      q_full;
  logic                      q_valid;
  logic                      push;
  logic                      pop;
  mck_pkg::job_t             push_job;
  mck_pkg::job_t             head_job;

  // Dot period register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= mck_pkg::DOT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dot_q <= cfg_data_i;
    end
  end

  assign busy = q_full;

  mck_front u_front (
    .start_i     (start),
    .full_i      (q_full),
    .character_i (character_i),
    .push_o      (push),
    .job_o       (push_job)
  );

  mck_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (head_job)
  );

  mck_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dot_period_i  (dot_q),
    .head_valid_i  (q_valid),
    .head_i        (head_job),
    .pop_o         (pop),
    .strobe_o      (strobe_o),
    .led_on_o      (led_on_o),
    .duration_ms_o (duration_ms_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

### src/mck_checker.sv
// Port-level checks of the Morse keyer segment sequence, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "morse_character_keyer_unit_defines.svh"

module mck_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic                       strobe_o,
  input logic                       led_on_o,
  input logic [mck_pkg::DUR_W-1:0]  duration_ms_o,
  input logic                       last_o
);

  logic mark_seg;
  logic inner_space;

  // Segment kinds as seen on the result ports.
  assign mark_seg    = strobe_o && led_on_o;
  assign inner_space = strobe_o && !led_on_o && !last_o;

  // A lit segment never ends a character.
  `MCK_ASSERT_IMP(a_mark_not_last, clk_i, rst_ni, mark_seg, !last_o, "mark flagged last")

  // Every lit segment is followed at once by a dark one-unit space.
  `MCK_ASSERT_NXT(a_mark_then_space, clk_i, rst_ni, mark_seg, inner_space, "mark without space")

  // A dark segment inside a letter is always followed by another segment.
  `MCK_ASSERT_NXT(a_space_continues, clk_i, rst_ni, inner_space, strobe_o, "letter cut short")

  // The configuration channel never refuses a write.
  `MCK_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "write refused")

endmodule

bind morse_character_keyer_unit mck_checker u_mck_checker (.*);

`default_nettype wire

### tb/sv/tb_morse_character_keyer_unit.sv
// Self-checking testbench for the Morse character keyer unit.
`timescale 1ns / 1ps

module tb_morse_character_keyer_unit;

  localparam int unsigned CHAR_W = mck_pkg::CHAR_W;
  localparam int unsigned DOT_W  = mck_pkg::DOT_W;
  localparam int unsigned DUR_W  = mck_pkg::DUR_W;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [DOT_W-1:0] PERIOD_AFTER_RESET = 10'd100;

  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

  // Segment lengths counted in dot periods.
  localparam int unsigned DOT_UNITS        = 1;
  localparam int unsigned DASH_UNITS       = 3;
  localparam int unsigned SYMBOL_GAP_UNITS = 1;
  localparam int unsigned LETTER_GAP_UNITS = 2;
  localparam int unsigned WORD_GAP_UNITS   = 4;

  typedef struct packed {
    logic             led_on;
    logic [DUR_W-1:0] duration_ms;
    logic             last;
  } segment_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CHAR_W-1:0] character_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [DOT_W-1:0]  cfg_data_i;
  logic              strobe_o;
  logic              led_on_o;
  logic [DUR_W-1:0]  duration_ms_o;
  logic              last_o;

  // Shadow of the dot period register and the segments still to come.
  logic [DOT_W-1:0] dot_period;
  segment_t         pending_segments[$];
  int unsigned      mismatches;
  int unsigned      cycles;

  morse_character_keyer_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .character_i  (character_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .strobe_o     (strobe_o),
    .led_on_o     (led_on_o),
    .duration_ms_o(duration_ms_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // International Morse code of each letter, A first.
  function automatic string morse_of(input int idx);
    case (idx)
      0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
      4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
      8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
      12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
      16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
      20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
      24: return "-.--";  default: return "--..";
    endcase
  endfunction

  function automatic void push_segment(input logic led, input int unsigned units,
                                       input logic fin);
    segment_t seg;
    seg.led_on      = led;
    seg.duration_ms = DUR_W'(dot_period * units);
    seg.last        = fin;
    pending_segments.push_back(seg);
  endfunction

  // Queues the segments that keying one character produces and returns how many.
  function automatic int predict_keying(input logic [CHAR_W-1:0] ch);
    string code;
    int    idx;
    int    i;
    idx = -1;
    if (ch == ASCII_SPACE) begin
      push_segment(1'b0, WORD_GAP_UNITS, 1'b1);
      return 1;
    end
    if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) idx = ch - ASCII_UPPER_A;
    else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) idx = ch - ASCII_LOWER_A;
    if (idx < 0) return 0;
    code = morse_of(idx);
    for (i = 0; i < code.len(); i++) begin
      push_segment(1'b1, (code[i] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0);
      push_segment(1'b0, SYMBOL_GAP_UNITS, 1'b0);
    end
    push_segment(1'b0, LETTER_GAP_UNITS, 1'b1);
    return 2 * code.len() + 1;
  endfunction

  // Mostly letters of either case, some spaces, the rest any code at all.
  function automatic logic [CHAR_W-1:0] random_character();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 1) == 0) return ASCII_UPPER_A + CHAR_W'($urandom_range(0, 25));
      return ASCII_LOWER_A + CHAR_W'($urandom_range(0, 25));
    end
    if (pick < 85) return ASCII_SPACE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Offers one character and waits for its transfer; start is left high so
  // that a following character can go out on the next cycle.
  task automatic send_character(input logic [CHAR_W-1:0] ch, output int produced);
    @(negedge clk_i);
    start       <= 1'b1;
    character_i <= ch;
    do @(posedge clk_i); while (busy);
    produced = predict_keying(ch);
  endtask

  task automatic pause_sender(input int unsigned gap);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (gap - 1) @(negedge clk_i);
  endtask

  // Waits for every expected segment, then idles a while so a stray late segment is caught.
  task automatic wait_until_quiet();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_segments.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_dot_period(input logic [DOT_W-1:0] value);
    wait_until_quiet();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    dot_period = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Edges of the letter ranges, both cases, one- and four-symbol letters and
  // codes that give no segment, all at the period left by reset.
  task automatic test_reset_period();
    logic [CHAR_W-1:0] chars[$];
    int                produced;
    chars = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h20, 8'h45, 8'h54, 8'h51,
              8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'h30};
    foreach (chars[i]) send_character(chars[i], produced);
  endtask

  // Zero, the largest value and the bounds of the legal range.
  task automatic test_period_extremes();
    logic [DOT_W-1:0] periods[$];
    int               produced;
    periods = '{10'd0, 10'd1023, 10'd1, 10'd1000};
    foreach (periods[i]) begin
      write_dot_period(periods[i]);
      send_character(8'h4A, produced);
      send_character(ASCII_SPACE, produced);
    end
  endtask

  // Random characters until the given number of keyed ones have gone out.
  task automatic test_random_traffic(input logic [DOT_W-1:0] period, input int unsigned keyed,
                                     input bit with_gaps);
    int unsigned sent;
    int          produced;
    bit          quiet_stretch;
    sent = 0;
    quiet_stretch = 1'b0;
    write_dot_period(period);
    while (sent < keyed) begin
      if (sent % 32 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
      if (with_gaps && !quiet_stretch && $urandom_range(0, 2) == 0)
        pause_sender($urandom_range(1, 7));
      send_character(random_character(), produced);
      if (produced != 0) sent++;
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    character_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    dot_period  = PERIOD_AFTER_RESET;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_period();
    test_period_extremes();
    test_random_traffic(DOT_W'($urandom_range(1, 1000)), 100, 1'b1);
    test_random_traffic(10'd1023, 40, 1'b1);
    test_random_traffic(10'd0, 25, 1'b1);
    test_random_traffic(DOT_W'($urandom_range(0, 1023)), 90, 1'b1);
    test_random_traffic(PERIOD_AFTER_RESET, 85, 1'b0);
    wait_until_quiet();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Each strobed segment is checked against the oldest expected one.
  always @(posedge clk_i) begin
    segment_t want;
    if (rst_ni && strobe_o) begin
      if (pending_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected segment: led %0b dur %0d last %0b",
                   led_on_o, duration_ms_o, last_o);
      end else begin
        want = pending_segments.pop_front();
        if (want.led_on !== led_on_o || want.duration_ms !== duration_ms_o ||
            want.last !== last_o) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected led/dur/last %0b/%0d/%0b, got %0b/%0d/%0b",
                     want.led_on, want.duration_ms, want.last,
                     led_on_o, duration_ms_o, last_o);
        end
      end
    end
  end

  // Guard against a hung handshake or missing segments.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+src
src/mck_pkg.sv
src/mck_front.sv
src/mck_fifo.sv
src/mck_back.sv
src/morse_character_keyer_unit.sv
src/mck_checker.sv
tb/sv/tb_morse_character_keyer_unit.sv
